FILE: design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: list capacity,
// derived widths, command and status codes, and the control word that
// ple_ctrl broadcasts to every cell in the chain.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ_AT   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic                     rd;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

FILE: design/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One storage slot of the list. Compares its own slot number with the
// command index and takes the left neighbor (insert shift), the new value,
// the right neighbor (delete shift) or holds. Drives its value onto the
// read bus when addressed by a read.
// ----------------------------------------------------------------------------
module ple_cell (
  input  logic                              clk,
  input  logic [ple_pkg::IDX_W-1:0]         slot,
  input  ple_pkg::cell_ctl_t                ctl,
  input  logic signed [ple_pkg::DATA_W-1:0] left,
  input  logic signed [ple_pkg::DATA_W-1:0] right,
  output logic signed [ple_pkg::DATA_W-1:0] data,
  output logic signed [ple_pkg::DATA_W-1:0] rd_data
);
  import ple_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.ins && (slot > ctl.idx)) begin
      data <= left;
    end else if (ctl.ins && (slot == ctl.idx)) begin
      data <= ctl.value;
    end else if (ctl.del && (slot >= ctl.idx)) begin
      data <= right;
    end
  end

  assign rd_data = (ctl.rd && (slot == ctl.idx)) ? data : '0;

endmodule

FILE: design/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Command decode: checks the position against the entry count, picks the
// status, the slot index and the next count, and forms the control word
// for the cell chain. Shift and read enables are gated by fire.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic                              fire,
  input  logic [2:0]                        opcode,
  input  logic signed [ple_pkg::DATA_W-1:0] value,
  input  logic [ple_pkg::POS_W-1:0]         position,
  input  logic [ple_pkg::CNT_W-1:0]         fill,
  output ple_pkg::cell_ctl_t                ctl,
  output ple_pkg::status_t                  status,
  output logic [ple_pkg::CNT_W-1:0]         fill_next
);
  import ple_pkg::*;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] fill_x;
  logic             full;
  logic             empty;
  logic             pos_ok_ins;
  logic             pos_ok;
  logic [IDX_W-1:0] pos_idx;
  logic [IDX_W-1:0] back_idx;
  logic             ins;
  logic             del;
  logic             rd;
  logic [IDX_W-1:0] idx;

  assign pos_x      = CMP_W'(position);
  assign fill_x     = CMP_W'(fill);
  assign full       = (fill == CNT_W'(CAPACITY));
  assign empty      = (fill == '0);
  assign pos_ok_ins = (pos_x != '0) && (pos_x <= fill_x + CMP_W'(1));
  assign pos_ok     = (pos_x != '0) && (pos_x <= fill_x);
  assign pos_idx    = IDX_W'(pos_x - CMP_W'(1));
  assign back_idx   = IDX_W'(fill - CNT_W'(1));

  always_comb begin
    ins    = 1'b0;
    del    = 1'b0;
    rd     = 1'b0;
    idx    = '0;
    status = ST_OK;
    unique case (opcode)
      OP_INS_FRONT: begin
        if (full) status = ST_FULL;
        else ins = 1'b1;
      end
      OP_INS_BACK: begin
        idx = IDX_W'(fill);
        if (full) status = ST_FULL;
        else ins = 1'b1;
      end
      OP_INS_AT: begin
        idx = pos_idx;
        if (!pos_ok_ins) status = ST_BADPOS;
        else if (full) status = ST_FULL;
        else ins = 1'b1;
      end
      OP_DEL_FRONT: begin
        if (empty) status = ST_EMPTY;
        else del = 1'b1;
      end
      OP_DEL_BACK: begin
        idx = back_idx;
        if (empty) status = ST_EMPTY;
        else del = 1'b1;
      end
      OP_DEL_AT: begin
        idx = pos_idx;
        if (empty) status = ST_EMPTY;
        else if (!pos_ok) status = ST_BADPOS;
        else del = 1'b1;
      end
      OP_READ_AT: begin
        idx = pos_idx;
        if (empty) status = ST_EMPTY;
        else if (!pos_ok) status = ST_BADPOS;
        else rd = 1'b1;
      end
      default: status = ST_BADPOS;
    endcase
  end

  always_comb begin
    fill_next = fill;
    if (ins) fill_next = fill + CNT_W'(1);
    else if (del) fill_next = fill - CNT_W'(1);
  end

  assign ctl.ins   = fire && ins;
  assign ctl.del   = fire && del;
  assign ctl.rd    = fire && rd;
  assign ctl.idx   = idx;
  assign ctl.value = value;

endmodule

FILE: design/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Bounded ordered list of signed 32-bit values held in a chain of cells.
//
// Input channel (in_valid / in_stall) carries one command word: opcode,
// value and 1-based position. Output channel (out_valid / out_stall)
// returns one result word per command: status, entry count after the
// command and the value read (zero unless a read succeeds).
// For each command all cells shift or hold in parallel
// on a compare against the command index, and a read is an OR of the
// addressed cell's value. The result is captured in the output register
// in the cycle after acceptance, and throughput is one command per cycle
// while the receiver keeps up.
// in_stall is high only while a result waits and out_stall is high; the
// result register then holds and no command is taken. A result taken in
// the same cycle frees the register for the next command.
// Reset clears the entry count and the output valid; cell contents are
// not cleared and are never read before written. No clearing pass.
// ----------------------------------------------------------------------------
module positional_list_engine_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        opcode,
  input  logic signed [ple_pkg::DATA_W-1:0] value,
  input  logic [ple_pkg::POS_W-1:0]         position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [ple_pkg::CNT_W-1:0]         entry_count,
  output logic signed [ple_pkg::DATA_W-1:0] read_value
);
  import ple_pkg::*;

  logic                     fire;
  cell_ctl_t                ctl;
  status_t                  cmd_status;
  logic [CNT_W-1:0]         fill;
  logic [CNT_W-1:0]         fill_next;
  logic signed [DATA_W-1:0] cell_q  [CAPACITY];
  logic signed [DATA_W-1:0] rd_bus  [CAPACITY];
  logic signed [DATA_W-1:0] rd_any;

  assign in_stall = out_valid && out_stall;
  assign fire     = in_valid && !in_stall;

  ple_ctrl u_ctrl (
    .fire      (fire),
    .opcode    (opcode),
    .value     (value),
    .position  (position),
    .fill      (fill),
    .ctl       (ctl),
    .status    (cmd_status),
    .fill_next (fill_next)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = value;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    ple_cell u_cell (
      .clk     (clk),
      .slot    (IDX_W'(i)),
      .ctl     (ctl),
      .left    (left_d),
      .right   (right_d),
      .data    (cell_q[i]),
      .rd_data (rd_bus[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_any = rd_any | rd_bus[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status      <= cmd_status;
      entry_count <= fill_next;
      read_value  <= rd_any;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (entry_count == fill))
    else $error("reported count differs from held count");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (fire && (cmd_status != ST_OK)) |=> (fill == $past(fill)))
    else $error("rejected command changed the count");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (read_value == '0))
    else $error("read value nonzero on failed command");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> (fill == $past(fill) + CNT_W'(1)))
    else $error("insert did not grow the count");

endmodule
